// ===== design/ambd_pkg.sv =====
package ambd_pkg;

   // request word: one cpu bus access
   typedef struct packed {
      logic        cmd;
      logic [15:0] bus_address;
      logic [7:0]  write_byte;
   } req_type;

   // response word: decoded target and internally answered data
   typedef struct packed {
      logic [3:0]  target;
      logic [16:0] target_offset;
      logic        is_write;
      logic [7:0]  data_out;
      logic [7:0]  read_value;
      logic        read_internal;
      logic        nmi_request;
   } rsp_type;

   // access kinds
   localparam logic CMD_READ  = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   // target region codes
   localparam logic [3:0] TGT_NONE  = 4'd0;
   localparam logic [3:0] TGT_PROG  = 4'd1;
   localparam logic [3:0] TGT_WRAM  = 4'd2;
   localparam logic [3:0] TGT_CHAR  = 4'd3;
   localparam logic [3:0] TGT_RAMC  = 4'd4;
   localparam logic [3:0] TGT_VRAM  = 4'd5;
   localparam logic [3:0] TGT_COLS  = 4'd6;
   localparam logic [3:0] TGT_SPR   = 4'd7;
   localparam logic [3:0] TGT_PAL   = 4'd8;
   localparam logic [3:0] TGT_GFX   = 4'd9;
   localparam logic [3:0] TGT_SNDA  = 4'd10;
   localparam logic [3:0] TGT_SNDD  = 4'd11;
   localparam logic [3:0] TGT_SNDC  = 4'd12;
   localparam logic [3:0] TGT_VCTL  = 4'd13;

   // video control register offsets
   localparam logic [16:0] VCTL_PRIORITY = 17'd0;
   localparam logic [16:0] VCTL_ENABLE   = 17'd9;

   // configuration register indexes
   localparam int unsigned CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_PLAYER1 = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PLAYER2 = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SYSTEM  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXTRA_A = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXTRA_B = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_DIP_ONE = 3'd5;

   // address map constants
   localparam logic [15:0] MIRROR_MASK    = 16'hFF0F;
   localparam logic [16:0] BANK_HIGH_BASE = 17'h10000;
   localparam logic [16:0] FIXED_ROM_BASE = 17'h08000;
   localparam logic [15:0] GFX_PORT_ADDR  = 16'hD404;

   // masked mirror codes
   localparam logic [15:0] MIR_PLAYER1 = 16'hD408;
   localparam logic [15:0] MIR_PLAYER2 = 16'hD409;
   localparam logic [15:0] MIR_DIP_ONE = 16'hD40A;
   localparam logic [15:0] MIR_SYSTEM  = 16'hD40B;
   localparam logic [15:0] MIR_EXTRA_A = 16'hD40C;
   localparam logic [15:0] MIR_EXTRA_B = 16'hD40D;
   localparam logic [15:0] MIR_SNDA    = 16'hD40E;
   localparam logic [15:0] MIR_SNDD    = 16'hD40F;
   localparam logic [15:0] MIR_PRIO    = 16'hD300;

   // write strobes at fixed addresses
   localparam logic [15:0] WR_PTR_LOW  = 16'hD509;
   localparam logic [15:0] WR_PTR_HIGH = 16'hD50A;
   localparam logic [15:0] WR_SND_CMD  = 16'hD50B;
   localparam logic [15:0] WR_BANK_SEL = 16'hD50E;
   localparam logic [15:0] WR_VID_EN   = 16'hD600;

   localparam logic [7:0] OPEN_BUS = 8'hFF;

endpackage

// ===== design/arcade_main_bus_decoder.sv =====
// Main cpu bus decoder. Each request word is one read or write; each gives exactly one
// response word naming the target region and the offset within it, or a byte answered
// here (input ports, dip switch, status bytes, open bus 0xFF). A word passes through
// one request register, one decode pass and one response register. A new word is
// taken every cycle as long as the response side keeps up; the request stage only
// stalls when a response is held by rsp_stall and the request register is full. The
// graphics rom pointer and the program rom bank bit are updated in the decode pass,
// so their effect is seen by the very next word. Configuration writes (csr_ready is
// always high) set the input port bytes; indexes past the last register are ignored.
module arcade_main_bus_decoder (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  ambd_pkg::req_type                     req_word,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output ambd_pkg::rsp_type                     rsp_word,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [ambd_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [7:0]                            csr_data
);
   import ambd_pkg::*;

   logic        in_valid_ff;
   req_type     in_ff;
   logic        rsp_valid_ff;
   rsp_type     rsp_ff;
   logic [15:0] gfx_ptr_ff;
   logic [15:0] gfx_ptr_in;
   logic        bank_ff;
   logic        bank_in;
   logic [7:0]  player1_ff;
   logic [7:0]  player2_ff;
   logic [7:0]  system_ff;
   logic [7:0]  extra_a_ff;
   logic [7:0]  extra_b_ff;
   logic [7:0]  dip_one_ff;

   logic        out_free;
   logic        advance;
   logic        take_req;
   logic        csr_write;
   logic [15:0] addr;
   logic [15:0] mirror;
   logic [7:0]  wdata;
   logic [3:0]  tgt;
   logic [16:0] offset;
   logic [7:0]  val;
   logic        intl;
   logic        nmi;
   rsp_type     rsp_in;

   // handshake control
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign take_req  = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   assign addr   = in_ff.bus_address;
   assign mirror = in_ff.bus_address & MIRROR_MASK;
   assign wdata  = in_ff.write_byte;

   // address decode for the word in the request register
   always_comb begin
      tgt        = TGT_NONE;
      offset     = '0;
      val        = OPEN_BUS;
      intl       = 1'b0;
      nmi        = 1'b0;
      gfx_ptr_in = gfx_ptr_ff;
      bank_in    = bank_ff;
      if (in_ff.cmd == CMD_READ) begin
         if (addr < 16'h6000) begin
            tgt    = TGT_PROG;
            offset = {1'b0, addr};
         end else if (addr < 16'h8000) begin
            // banked window: lower bank maps straight through
            tgt    = TGT_PROG;
            offset = bank_ff ? (BANK_HIGH_BASE | {4'b0, addr[12:0]}) : {1'b0, addr};
         end else if (addr < 16'h8800) begin
            tgt    = TGT_WRAM;
            offset = {6'b0, addr[10:0]};
         end else if (addr == 16'h8800) begin
            val  = 8'h00;
            intl = 1'b1;
         end else if (addr == 16'h8801) begin
            val  = 8'hFF;
            intl = 1'b1;
         end else if (addr >= 16'hC000 && addr < 16'hC400) begin
            tgt    = TGT_RAMC;
            offset = {7'b0, addr[9:0]};
         end else if (addr >= 16'hC400 && addr < 16'hD000) begin
            tgt    = TGT_VRAM;
            offset = {1'b0, 16'(addr - 16'hC400)};
         end else if (addr >= 16'hD000 && addr < 16'hD060) begin
            tgt    = TGT_COLS;
            offset = {10'b0, addr[6:0]};
         end else if (addr >= 16'hD100 && addr < 16'hD180) begin
            tgt    = TGT_SPR;
            offset = {10'b0, addr[6:0]};
         end else if (addr >= 16'hD400 && addr < GFX_PORT_ADDR) begin
            // collision status never sets
            val  = 8'h00;
            intl = 1'b1;
         end else if (addr == GFX_PORT_ADDR) begin
            // gfx port: use pointer, then step it
            gfx_ptr_in = gfx_ptr_ff + 16'd1;
            if (!gfx_ptr_ff[15]) begin
               tgt    = TGT_GFX;
               offset = {1'b0, gfx_ptr_ff};
            end else begin
               val  = 8'h00;
               intl = 1'b1;
            end
         end else begin
            unique case (mirror)
               MIR_PLAYER1: begin
                  val  = player1_ff;
                  intl = 1'b1;
               end
               MIR_PLAYER2: begin
                  val  = player2_ff;
                  intl = 1'b1;
               end
               MIR_DIP_ONE: begin
                  val  = dip_one_ff;
                  intl = 1'b1;
               end
               MIR_SYSTEM: begin
                  val  = system_ff;
                  intl = 1'b1;
               end
               MIR_EXTRA_A: begin
                  val  = extra_a_ff;
                  intl = 1'b1;
               end
               MIR_EXTRA_B: begin
                  val  = extra_b_ff;
                  intl = 1'b1;
               end
               MIR_SNDD: begin
                  tgt = TGT_SNDD;
               end
               default: begin
                  if (addr >= 16'hE000 && addr < 16'hF000) begin
                     tgt    = TGT_PROG;
                     offset = FIXED_ROM_BASE | {5'b0, addr[11:0]};
                  end else begin
                     val  = OPEN_BUS;
                     intl = 1'b1;
                  end
               end
            endcase
         end
      end else begin
         if (addr < 16'h8000) begin
            tgt = TGT_NONE;
         end else if (addr < 16'h8800) begin
            tgt    = TGT_WRAM;
            offset = {6'b0, addr[10:0]};
         end else if (addr >= 16'h9000 && addr < 16'hC000) begin
            tgt    = TGT_CHAR;
            offset = {1'b0, 16'(addr - 16'h9000)};
         end else if (addr >= 16'hC000 && addr < 16'hC400) begin
            tgt    = TGT_RAMC;
            offset = {7'b0, addr[9:0]};
         end else if (addr >= 16'hC400 && addr < 16'hD000) begin
            tgt    = TGT_VRAM;
            offset = {1'b0, 16'(addr - 16'hC400)};
         end else if (addr >= 16'hD000 && addr < 16'hD060) begin
            tgt    = TGT_COLS;
            offset = {10'b0, addr[6:0]};
         end else if (addr >= 16'hD100 && addr < 16'hD180) begin
            tgt    = TGT_SPR;
            offset = {10'b0, addr[6:0]};
         end else if (addr >= 16'hD200 && addr < 16'hD280) begin
            tgt    = TGT_PAL;
            offset = {10'b0, addr[6:0]};
         end else if (mirror == MIR_PRIO) begin
            tgt    = TGT_VCTL;
            offset = VCTL_PRIORITY;
         end else if (mirror == MIR_SNDA) begin
            tgt = TGT_SNDA;
         end else if (mirror == MIR_SNDD) begin
            tgt = TGT_SNDD;
         end else if (addr >= 16'hD500 && addr < 16'hD508) begin
            // scroll and color bank registers sit after priority
            tgt    = TGT_VCTL;
            offset = {13'b0, 4'({1'b0, addr[2:0]} + 4'd1)};
         end else begin
            unique case (addr)
               WR_PTR_LOW: begin
                  gfx_ptr_in = {gfx_ptr_ff[15:8], wdata};
               end
               WR_PTR_HIGH: begin
                  gfx_ptr_in = {wdata, gfx_ptr_ff[7:0]};
               end
               WR_SND_CMD: begin
                  tgt = TGT_SNDC;
                  nmi = 1'b1;
               end
               WR_BANK_SEL: begin
                  bank_in = wdata[7];
               end
               WR_VID_EN: begin
                  tgt    = TGT_VCTL;
                  offset = VCTL_ENABLE;
               end
               default: begin
                  tgt = TGT_NONE;
               end
            endcase
         end
      end
   end

   // response word
   always_comb begin
      rsp_in.target        = tgt;
      rsp_in.target_offset = offset;
      rsp_in.is_write      = (in_ff.cmd == CMD_WRITE) && (tgt != TGT_NONE);
      rsp_in.data_out      = (in_ff.cmd == CMD_WRITE) ? wdata : 8'h00;
      rsp_in.read_value    = intl ? val : OPEN_BUS;
      rsp_in.read_internal = intl;
      rsp_in.nmi_request   = nmi;
   end

   // request register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (take_req) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
      if (take_req) begin
         in_ff <= req_word;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   // pointer and bank state
   always_ff @(posedge clock) begin
      if (reset) begin
         gfx_ptr_ff <= '0;
         bank_ff    <= 1'b0;
      end else if (advance) begin
         gfx_ptr_ff <= gfx_ptr_in;
         bank_ff    <= bank_in;
      end
   end

   // input port bytes
   always_ff @(posedge clock) begin
      if (reset) begin
         player1_ff <= 8'hFF;
         player2_ff <= 8'hFF;
         system_ff  <= 8'hFF;
         extra_a_ff <= 8'hFF;
         extra_b_ff <= 8'hFF;
         dip_one_ff <= 8'hFF;
      end else if (csr_write) begin
         case (csr_index)
            CSR_PLAYER1: player1_ff <= csr_data;
            CSR_PLAYER2: player2_ff <= csr_data;
            CSR_SYSTEM:  system_ff  <= csr_data;
            CSR_EXTRA_A: extra_a_ff <= csr_data;
            CSR_EXTRA_B: extra_b_ff <= csr_data;
            CSR_DIP_ONE: dip_one_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   // gfx port read steps the pointer by one
   a_gfx_step: assert property (@(posedge clock) disable iff (reset)
      (advance && in_ff.cmd == CMD_READ && addr == GFX_PORT_ADDR)
      |=> (gfx_ptr_ff == 16'($past(gfx_ptr_ff) + 16'd1)))
      else $error("gfx pointer did not step after port read");

   // a held response is not overwritten
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !advance)
      else $error("response overwritten while stalled");

   // nmi only with a sound command write
   a_nmi_cmd: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.nmi_request)
      |-> (rsp_ff.target == TGT_SNDC && rsp_ff.is_write))
      else $error("nmi request without sound command write");

   // memory-supplied reads and writes carry open bus
   a_open_bus: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.read_internal) |-> (rsp_ff.read_value == OPEN_BUS))
      else $error("read value not open bus");

endmodule
